/* hw/rtl/gsv_pkg.sv */
// Package for the group sum variance score core: payload structs, codes,
// widths and saturation limits. No dependencies.
`default_nettype none

package gsv_pkg;

  // Value table geometry (fixed by the payload field widths)
  localparam int unsigned MaxMembers = 256;
  localparam int unsigned ValueBits  = 8;
  localparam int unsigned AddrBits   = $clog2(MaxMembers);

  localparam int unsigned CfgBits    = 9;
  localparam int unsigned GroupBits  = 17;  // up to 511 members * 255
  localparam int unsigned TotalBits  = 26;
  localparam int unsigned SquareBits = 44;
  localparam int unsigned SqBits     = 2 * GroupBits;
  localparam int unsigned LhsBits    = SquareBits + CfgBits;
  localparam int unsigned RhsBits    = 2 * TotalBits;
  localparam int unsigned DenBits    = 2 * CfgBits;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned DivBits    = LhsBits + FracBits;  // dividend width
  localparam int unsigned VarBits    = 40;
  localparam int unsigned OutBits    = 16;
  localparam int unsigned DivCntBits = $clog2(DivBits);
  localparam int unsigned SplitLo    = SquareBits / 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SCORE = 1'b1
  } op_e;

  typedef enum logic {
    CFG_PLAYERS_PER_TEAM = 1'b0,
    CFG_TEAM_COUNT       = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SQ,
    FS_LHS_LO,
    FS_LHS_HI,
    FS_NUM,
    FS_DIV,
    FS_DONE
  } fin_state_e;

  typedef struct packed {
    op_e                  operation;
    logic [AddrBits-1:0]  index;
    logic [ValueBits-1:0] value;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [VarBits-1:0] variance_q8;
    logic [OutBits-1:0] min_group_sum;
    logic [OutBits-1:0] max_group_sum;
    logic [OutBits-1:0] spread;
  } out_item_t;

endpackage

`default_nettype wire

/* hw/rtl/gsv_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module gsv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/group_sum_variance_score_core.sv */
// Group sum variance score core: value table in gsv_ram, group accumulation
// pipeline and a sequential variance finisher. Depends on gsv_pkg, gsv_ram.
`default_nettype none

// Usage
//   Input (in_valid_i / in_stall_o / in_data_i): one transaction per item. A load
//   writes value into table entry index; a score looks up entry index and adds it
//   to the open group, which closes after players_per_team scores. The score with
//   last set closes the group even if partial and yields exactly one result.
//   Output (out_valid_o / out_stall_i / out_data_o): one transaction per
//   permutation: Q8 variance of the group sums over team_count groups, min and
//   max group sum and their spread.
//   Config: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 players_per_team, 1 team_count). Write only while the core is idle.
// Throughput / result path
//   Loads and non-last scores: one per cycle while the input is not stalled, no result.
//   Last score: result registered after 3 stages of lookup/square/accumulate,
//   4 multiply steps, 61 restoring divide steps (one quotient bit each) and the
//   load of the output register.
//   Input stalls from a last item until its result is loaded into the output
//   register; a result held by out_stall_i only delays the next result.
// Reset
//   Clears accumulators and control; registers go to 4 / 4. The value table
//   is not cleared: entries are undefined until loaded.

module group_sum_variance_score_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire gsv_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output gsv_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire gsv_pkg::cfg_reg_e             cfg_index_i,
  input  wire logic [gsv_pkg::CfgBits-1:0]   cfg_wdata_i
);

  import gsv_pkg::*;

  localparam logic [TotalBits-1:0]  TotalCap  = '1;
  localparam logic [SquareBits-1:0] SquareCap = '1;
  localparam logic [VarBits-1:0]    VarCap    = '1;
  localparam logic [OutBits-1:0]    OutCap    = '1;
  localparam logic [CfgBits-1:0]    CfgReset  = CfgBits'(4);

  // ---------------- config registers ----------------
  logic [CfgBits-1:0] ppt_q, teams_q;
  logic [CfgBits-1:0] ppt_eff, n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppt_q   <= CfgReset;
      teams_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PLAYERS_PER_TEAM: ppt_q   <= cfg_wdata_i;
        CFG_TEAM_COUNT:       teams_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero acts as one
  assign ppt_eff = (ppt_q == '0) ? CfgBits'(1) : ppt_q;
  assign n_eff   = (teams_q == '0) ? CfgBits'(1) : teams_q;

  // ---------------- input side / table ----------------
  logic in_acc, is_score, busy_q, out_load;
  logic [ValueBits-1:0] rdata;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_score   = (in_data_i.operation == OP_SCORE);

  gsv_ram #(
    .Width(ValueBits),
    .Depth(MaxMembers)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (in_acc && !is_score),
    .re_i   (in_acc && is_score),
    .addr_i (in_data_i.index),
    .wdata_i(in_data_i.value),
    .rdata_o(rdata)
  );

  // busy from acceptance of a last score item until its result is registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_acc && is_score && in_data_i.last) begin
      busy_q <= 1'b1;
    end else if (out_load) begin
      busy_q <= 1'b0;
    end
  end

  // ---------------- S1: group accumulation ----------------
  logic s1_v_q, s1_last_q;
  logic [CfgBits-1:0]   pos_q;
  logic [GroupBits-1:0] group_q;
  logic [GroupBits-1:0] gs_new;
  logic [CfgBits:0]     pos_new;
  logic                 s1_close;

  assign gs_new   = group_q + GroupBits'(rdata);
  assign pos_new  = {1'b0, pos_q} + (CfgBits+1)'(1);
  assign s1_close = (pos_new >= {1'b0, ppt_eff}) || s1_last_q;

  logic s2_v_q, s2_last_q;
  logic [GroupBits-1:0] s2_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      pos_q     <= '0;
      group_q   <= '0;
      s2_v_q    <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s1_v_q    <= in_acc && is_score;
      s1_last_q <= in_data_i.last;
      s2_v_q    <= s1_v_q && s1_close;
      s2_last_q <= s1_last_q;
      if (s1_v_q) begin
        if (s1_close) begin
          pos_q   <= '0;
          group_q <= '0;
        end else begin
          pos_q   <= pos_new[CfgBits-1:0];
          group_q <= gs_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sum_q <= gs_new;
  end

  // ---------------- S2: square of closed group ----------------
  logic s3_v_q, s3_last_q;
  logic [GroupBits-1:0] s3_sum_q;
  logic [SqBits-1:0]    s3_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q    <= 1'b0;
      s3_last_q <= 1'b0;
    end else begin
      s3_v_q    <= s2_v_q;
      s3_last_q <= s2_v_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_sum_q <= s2_sum_q;
    s3_sq_q  <= s2_sum_q * s2_sum_q;
  end

  // ---------------- S3: permutation accumulators ----------------
  logic [TotalBits-1:0]  total_q;
  logic [SquareBits-1:0] square_q;
  logic [GroupBits-1:0]  min_q, max_q;
  logic [TotalBits:0]    total_add;
  logic [SquareBits:0]   square_add;

  assign total_add  = {1'b0, total_q} + (TotalBits+1)'(s3_sum_q);
  assign square_add = {1'b0, square_q} + (SquareBits+1)'(s3_sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      square_q <= '0;
      min_q    <= '1;
      max_q    <= '0;
    end else if (out_load) begin
      total_q  <= '0;
      square_q <= '0;
      min_q    <= '1;
      max_q    <= '0;
    end else if (s3_v_q) begin
      total_q  <= total_add[TotalBits] ? TotalCap : total_add[TotalBits-1:0];
      square_q <= square_add[SquareBits] ? SquareCap : square_add[SquareBits-1:0];
      if (s3_sum_q < min_q) min_q <= s3_sum_q;
      if (s3_sum_q > max_q) max_q <= s3_sum_q;
    end
  end

  // ---------------- finisher: variance = (n*S2 - S1^2) * 256 / n^2 ----------
  fin_state_e fsm_q, fsm_d;
  logic [RhsBits-1:0]    rhs_q;
  logic [LhsBits-1:0]    lhs_q;
  logic [DenBits-1:0]    den_q;
  logic [DenBits-1:0]    rem_q;
  logic [DivBits-1:0]    quo_q;
  logic [DivCntBits-1:0] cnt_q;
  logic [DenBits:0]      rem_sh;
  logic                  q_bit;
  logic [LhsBits-1:0]    num;
  logic [VarBits-1:0]    var_sat;

  assign rem_sh  = {rem_q, quo_q[DivBits-1]};
  assign q_bit   = (rem_sh >= {1'b0, den_q});
  assign num     = (LhsBits'(rhs_q) < lhs_q) ? lhs_q - LhsBits'(rhs_q) : '0;
  assign var_sat = (|quo_q[DivBits-1:VarBits]) ? VarCap : quo_q[VarBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= FS_IDLE;
    end else begin
      fsm_q <= fsm_d;
    end
  end

  always_comb begin
    fsm_d    = fsm_q;
    out_load = 1'b0;
    case (fsm_q)
      FS_IDLE:   if (s3_last_q) fsm_d = FS_SQ;
      FS_SQ:     fsm_d = FS_LHS_LO;
      FS_LHS_LO: fsm_d = FS_LHS_HI;
      FS_LHS_HI: fsm_d = FS_NUM;
      FS_NUM:    fsm_d = FS_DIV;
      FS_DIV:    if (cnt_q == '0) fsm_d = FS_DONE;
      FS_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          fsm_d    = FS_IDLE;
        end
      end
      default:   fsm_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (fsm_q)
      FS_SQ:     rhs_q <= total_q * total_q;
      FS_LHS_LO: lhs_q <= LhsBits'(n_eff * square_q[SplitLo-1:0]);
      FS_LHS_HI: lhs_q <= lhs_q
                          + (LhsBits'(n_eff * square_q[SquareBits-1:SplitLo]) << SplitLo);
      FS_NUM: begin
        quo_q <= {num, FracBits'(0)};
        rem_q <= '0;
        den_q <= n_eff * n_eff;
        cnt_q <= DivCntBits'(DivBits - 1);
      end
      FS_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_q <= q_bit ? DenBits'(rem_sh - {1'b0, den_q}) : rem_sh[DenBits-1:0];
        quo_q <= {quo_q[DivBits-2:0], q_bit};
        cnt_q <= cnt_q - DivCntBits'(1);
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  logic [GroupBits-1:0] spread_full;
  assign spread_full = (max_q >= min_q) ? max_q - min_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_o.variance_q8   <= var_sat;
      out_data_o.min_group_sum <= min_q[GroupBits-1] ? OutCap : min_q[OutBits-1:0];
      out_data_o.max_group_sum <= max_q[GroupBits-1] ? OutCap : max_q[OutBits-1:0];
      out_data_o.spread        <= spread_full[GroupBits-1] ? OutCap
                                                           : spread_full[OutBits-1:0];
    end
  end

  // ---------------- assertions ----------------
  a_fin_only_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q != FS_IDLE |-> busy_q)
    else $error("finisher active without a pending last transaction");

  a_pipe_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q != FS_IDLE |-> !s1_v_q && !s2_v_q && !s3_v_q)
    else $error("accumulation pipeline busy during finish");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == FS_DIV |-> rem_q < den_q)
    else $error("divider remainder out of range");

  a_clear_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> total_q == '0 && square_q == '0 && max_q == '0 && !busy_q)
    else $error("accumulators not cleared after result");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fsm_q == FS_DONE))
    else $error("result registered outside the done state");

endmodule

`default_nettype wire
